FILE: design/dcmd_pkg.sv
// shared types, constants and helpers for the debounced cursor matrix driver
package dcmd_pkg;

  localparam int unsigned CfgWidth  = 10;
  localparam int unsigned NumBtn    = 4;
  localparam int unsigned GridSize  = 8;
  localparam int unsigned LineWidth = 8;
  localparam int unsigned PosWidth  = 4;
  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam int unsigned BtnUp    = 0;
  localparam int unsigned BtnDown  = 1;
  localparam int unsigned BtnRight = 2;
  localparam int unsigned BtnLeft  = 3;

  localparam logic [PosWidth-1:0] PosMin   = PosWidth'(1);
  localparam logic [PosWidth-1:0] PosMax   = PosWidth'((GridSize > 15) ? 15 : GridSize);
  localparam logic [PosWidth-1:0] PosReset = PosWidth'(4);

  localparam logic [CfgWidth-1:0] ThresholdReset = CfgWidth'(400);
  localparam logic [CfgWidth-1:0] CeilingReset   = CfgWidth'(1000);
  localparam logic [CfgWidth-1:0] FallbackReset  = CfgWidth'(500);

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_CEILING   = 2'd1,
    REG_FALLBACK  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic up_n;
    logic down_n;
    logic right_n;
    logic left_n;
  } btn_in_t;

  typedef struct packed {
    logic [LineWidth-1:0] row_lines;
    logic [LineWidth-1:0] col_lines;
    logic [PosWidth-1:0]  row_pos;
    logic [PosWidth-1:0]  col_pos;
  } cursor_out_t;

  typedef struct packed {
    logic [CfgWidth-1:0] threshold;
    logic [CfgWidth-1:0] ceiling;
    logic [CfgWidth-1:0] fallback;
  } cfg_t;

  function automatic logic [PosWidth-1:0] step_dec(input logic [PosWidth-1:0] p);
    return (p > PosMin) ? p - PosWidth'(1) : p;
  endfunction

  function automatic logic [PosWidth-1:0] step_inc(input logic [PosWidth-1:0] p);
    return (p < PosMax) ? p + PosWidth'(1) : p;
  endfunction

endpackage

FILE: design/dcmd_regs.sv
// apb configuration registers for threshold, ceiling and fallback
module dcmd_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dcmd_pkg::AddrWidth-1:0]  paddr,
  input  logic [dcmd_pkg::DataWidth-1:0]  pwdata,
  output logic [dcmd_pkg::DataWidth-1:0]  prdata,
  output logic                            pready,
  output dcmd_pkg::cfg_t                  cfg_o
);
  import dcmd_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= ThresholdReset;
      cfg_q.ceiling   <= CeilingReset;
      cfg_q.fallback  <= FallbackReset;
    end else if (wr_en) begin
      case (idx)
        REG_THRESHOLD: cfg_q.threshold <= pwdata[CfgWidth-1:0];
        REG_CEILING:   cfg_q.ceiling   <= pwdata[CfgWidth-1:0];
        REG_FALLBACK:  cfg_q.fallback  <= pwdata[CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = DataWidth'(cfg_q.threshold);
      REG_CEILING:   prdata = DataWidth'(cfg_q.ceiling);
      REG_FALLBACK:  prdata = DataWidth'(cfg_q.fallback);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/dcmd_core.sv
// input register, hold counters, cursor positions and matrix line decode
module dcmd_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dcmd_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  input  dcmd_pkg::btn_in_t      in_data_i,
  output logic                   in_ready_o,
  input  logic                   res_room_i,
  output logic                   res_push_o,
  output dcmd_pkg::cursor_out_t  res_data_o,
  output logic                   stage_valid_o
);
  import dcmd_pkg::*;

  logic                 in_valid_q;
  btn_in_t              in_data_q;
  logic                 advance;

  logic [CfgWidth-1:0]  cnt_q [NumBtn];
  logic [CfgWidth-1:0]  cnt_d [NumBtn];
  logic [PosWidth-1:0]  row_q, row_d;
  logic [PosWidth-1:0]  col_q, col_d;
  logic [NumBtn-1:0]    lvl;
  logic [NumBtn-1:0]    move;

  assign advance    = in_valid_q && res_room_i;
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    logic                held;
    logic [CfgWidth-1:0] c;
    lvl[BtnUp]    = in_data_q.up_n;
    lvl[BtnDown]  = in_data_q.down_n;
    lvl[BtnRight] = in_data_q.right_n;
    lvl[BtnLeft]  = in_data_q.left_n;
    move = '0;
    for (int i = 0; i < NumBtn; i++) begin
      held = !lvl[i];
      c    = cnt_q[i];
      if (held) begin
        c = (c >= cfg_i.ceiling) ? cfg_i.fallback : c + CfgWidth'(1);
      end
      if (!held && c >= cfg_i.threshold) begin
        move[i]  = 1'b1;
        cnt_d[i] = '0;
      end else begin
        cnt_d[i] = c;
      end
    end

    col_d = col_q;
    if (move[BtnUp]) col_d = step_dec(col_d);
    if (move[BtnDown]) col_d = step_inc(col_d);
    row_d = row_q;
    if (move[BtnRight]) row_d = step_dec(row_d);
    if (move[BtnLeft]) row_d = step_inc(row_d);

    for (int i = 0; i < LineWidth; i++) begin
      res_data_o.row_lines[i] = (row_d == PosWidth'(i + 1));
      res_data_o.col_lines[i] = (col_d != PosWidth'(i + 1));
    end
    res_data_o.row_pos = row_d;
    res_data_o.col_pos = col_d;
  end

  assign res_push_o    = advance;
  assign stage_valid_o = in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      row_q      <= PosReset;
      col_q      <= PosReset;
      for (int i = 0; i < NumBtn; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        row_q <= row_d;
        col_q <= col_d;
        for (int i = 0; i < NumBtn; i++) begin
          cnt_q[i] <= cnt_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

endmodule

FILE: design/dcmd_outq.sv
// two-entry result queue that decouples the core from the output channel
module dcmd_outq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  dcmd_pkg::cursor_out_t  push_data_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dcmd_pkg::cursor_out_t  out_data_o
);
  import dcmd_pkg::*;

  localparam int unsigned Depth    = 2;
  localparam int unsigned PtrWidth = $clog2(Depth);
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  cursor_out_t          entry_q [Depth];
  logic [PtrWidth-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]  cnt_q;
  logic                 pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (cnt_q != CntWidth'(Depth)) || pop;
  assign out_data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + CntWidth'(1);
        2'b01:   cnt_q <= cnt_q - CntWidth'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/debounced_cursor_matrix_driver_top.sv
// top level of the debounced cursor matrix driver
// One button sample is taken per clock and yields one result while the result
// queue has room. A sample goes into an input register; with room, its four
// hold counters and the cursor position are updated in a single pass and the
// matrix drive is written into a two-entry result queue. The sustained rate is
// one transaction per cycle while the queue has room, set by the per-sample
// counter and position update. Input is still taken while a result waits for
// the output side, until the queue fills. Configuration writes belong in idle time.
module debounced_cursor_matrix_driver_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  dcmd_pkg::btn_in_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dcmd_pkg::cursor_out_t           out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dcmd_pkg::AddrWidth-1:0]  paddr,
  input  logic [dcmd_pkg::DataWidth-1:0]  pwdata,
  output logic [dcmd_pkg::DataWidth-1:0]  prdata,
  output logic                            pready
);
  import dcmd_pkg::*;

  cfg_t        cfg;
  logic        res_room;
  logic        res_push;
  cursor_out_t res_data;
  logic        stage_valid;

  dcmd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dcmd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .in_ready_o    (in_ready_o),
    .res_room_i    (res_room),
    .res_push_o    (res_push),
    .res_data_o    (res_data),
    .stage_valid_o (stage_valid)
  );

  dcmd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_data),
    .room_o      (res_room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_accept_loads_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> stage_valid)
    else $error("accepted transaction did not reach the input register");

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.row_pos != '0 && out_data_o.col_pos != '0))
    else $error("cursor position left its range");

  a_row_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.row_pos <= PosWidth'(LineWidth))
      |-> $onehot(out_data_o.row_lines))
    else $error("row drive is not one-hot");

  a_col_onecold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(~out_data_o.col_lines) <= 1))
    else $error("more than one column driven");

endmodule
